@@ rtl/core/mfds_pkg.sv @@
package mfds_pkg;

  localparam int LANES     = 4;
  localparam int SAMPLE_W  = 32;
  localparam int TICK_W    = 32;
  localparam int LEN_W     = 7;
  localparam int CHAN_W    = 8;
  localparam int DELAY_W   = 14;
  localparam int WHOLE_W   = 6;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // lane order inside a memory word
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_ACC = 2;
  localparam int LANE_LEN = 3;

  localparam logic [LEN_W-1:0] MIN_LEN   = 7'd2;
  localparam logic [LEN_W-1:0] RESET_LEN = 7'd64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_PRIME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_CH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_ERR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_CH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_ERR  = 3'd4;

  typedef enum logic [2:0] {
    K_WRITE,
    K_PRIME,
    K_READ_NOW,
    K_READ_INTERP,
    K_READ_BLANK
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic [CHAN_W-1:0]              chan;
    logic [TICK_W-1:0]              tick;
    logic [LANES-1:0][SAMPLE_W-1:0] data;
    logic [WHOLE_W-1:0]             whole;
    logic [FRAC_W-1:0]              frac;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   pos_ch;
    logic [SAMPLE_W-1:0] pos_err;
    logic [CHAN_W-1:0]   vel_ch;
    logic [SAMPLE_W-1:0] vel_err;
  } err_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ISSUE,
    ST_PRIME,
    ST_RD_NOW,
    ST_RD_LEFT,
    ST_RD_DATA,
    ST_MUL,
    ST_SUM,
    ST_OFS,
    ST_EMIT
  } back_state_t;

  function automatic logic [SAMPLE_W-1:0] sat_add(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      sat_add = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/mfds_if.sv @@
interface mfds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  channel;
  logic [31:0] tick;
  logic [31:0] pos_in;
  logic [31:0] vel_in;
  logic [31:0] acc_in;
  logic [31:0] len_in;
  logic [13:0] delay;

  modport source (output valid, cmd, channel, tick, pos_in, vel_in, acc_in, len_in, delay,
                  input ready);
  modport sink (input valid, cmd, channel, tick, pos_in, vel_in, acc_in, len_in, delay,
                output ready);
endinterface

interface mfds_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  channel_out;
  logic [31:0] pos_out;
  logic [31:0] vel_out;
  logic [31:0] acc_out;
  logic [31:0] len_out;

  modport source (output valid, channel_out, pos_out, vel_out, acc_out, len_out,
                  input ready);
  modport sink (input valid, channel_out, pos_out, vel_out, acc_out, len_out,
                output ready);
endinterface

@@ rtl/core/mfds_ram.sv @@
module mfds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/core/mfds_front.sv @@
module mfds_front #(
  parameter int CHANNELS = 256
) (
  mfds_in_if.sink          samples,
  input  logic             q_ready,
  output logic             q_push,
  output mfds_pkg::item_t  q_item
);
  import mfds_pkg::*;

  logic  chan_ok;
  logic  keep;
  kind_t kind;

  assign chan_ok = 32'(samples.channel) < CHANNELS;

  always_comb begin
    keep = 1'b0;
    kind = K_READ_BLANK;
    unique case (samples.cmd)
      CMD_WRITE: begin
        keep = chan_ok;
        kind = K_WRITE;
      end
      CMD_PRIME: begin
        keep = chan_ok;
        kind = K_PRIME;
      end
      CMD_READ: begin
        keep = 1'b1;
        if (!chan_ok) begin
          kind = K_READ_BLANK;
        end else if (samples.delay == '0) begin
          kind = K_READ_NOW;
        end else begin
          kind = K_READ_INTERP;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_item.kind           = kind;
  assign q_item.chan           = samples.channel;
  assign q_item.tick           = samples.tick;
  assign q_item.data[LANE_POS] = samples.pos_in;
  assign q_item.data[LANE_VEL] = samples.vel_in;
  assign q_item.data[LANE_ACC] = samples.acc_in;
  assign q_item.data[LANE_LEN] = samples.len_in;
  assign q_item.whole          = samples.delay[DELAY_W-1:FRAC_W];
  assign q_item.frac           = samples.delay[FRAC_W-1:0];

  // unused commands are consumed and dropped here
  assign samples.ready = q_ready;
  assign q_push        = samples.valid && q_ready && keep;

endmodule

@@ rtl/core/mfds_queue.sv @@
module mfds_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfds_pkg::item_t  push_item,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output mfds_pkg::item_t  pop_item
);
  import mfds_pkg::*;

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_item   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/mfds_rem.sv @@
module mfds_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mfds_pkg::TICK_W-1:0]   tick,
  input  logic [mfds_pkg::WHOLE_W-1:0]  whole,
  input  logic [mfds_pkg::LEN_W-1:0]    len,
  output logic                          done,
  output logic [mfds_pkg::LEN_W-1:0]    slot,
  output logic [mfds_pkg::LEN_W-1:0]    whole_mod
);
  import mfds_pkg::*;

  // eight restoring remainder steps, one dividend byte
  function automatic logic [LEN_W-1:0] step8(input logic [LEN_W-1:0] r_in,
                                             input logic [7:0] b,
                                             input logic [LEN_W-1:0] d);
    logic [LEN_W:0]   t;
    logic [LEN_W-1:0] r;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[LEN_W-1:0];
    end
    step8 = r;
  endfunction

  logic              busy;
  logic [1:0]        cnt;
  logic [TICK_W-1:0] dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= tick;
      slot      <= '0;
      whole_mod <= step8('0, 8'(whole), len);
    end else if (busy) begin
      dvd  <= {dvd[TICK_W-9:0], 8'd0};
      slot <= step8(slot, dvd[TICK_W-1:TICK_W-8], len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/mfds_back.sv @@
module mfds_back #(
  parameter int CHANNELS = 256,
  parameter int DEPTH    = 64,
  localparam int ADDR_W  = $clog2(CHANNELS * DEPTH),
  localparam int WORD_W  = mfds_pkg::LANES * mfds_pkg::SAMPLE_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  mfds_pkg::item_t             q_item,
  output logic                        q_pop,
  input  logic [mfds_pkg::LEN_W-1:0]  eff_len,
  input  mfds_pkg::err_cfg_t          err_cfg,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [WORD_W-1:0]           mem_wdata,
  input  logic [WORD_W-1:0]           mem_rdata,
  mfds_out_if.source                  results
);
  import mfds_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);

  back_state_t state, state_next;

  item_t                          cur;
  logic [LEN_W-1:0]               slot_q;
  logic [LEN_W-1:0]               right_q;
  logic [LEN_W-1:0]               left_q;
  logic [SLOT_W-1:0]              cnt;
  logic [LANES-1:0][SAMPLE_W-1:0] rgt;
  logic signed [SAMPLE_W:0]       diff [LANES];
  logic signed [SAMPLE_W+9:0]     prod [LANES];
  logic [LANES-1:0][SAMPLE_W-1:0] val;
  logic [LANES-1:0][SAMPLE_W-1:0] res;

  logic                           out_vld;
  logic [CHAN_W-1:0]              out_chan;
  logic [LANES-1:0][SAMPLE_W-1:0] out_data;

  logic              rem_start;
  logic              rem_done;
  logic [LEN_W-1:0]  rem_slot;
  logic [LEN_W-1:0]  rem_whole;
  logic [LEN_W-1:0]  right_c;
  logic [ADDR_W-1:0] base_addr;
  logic              prime_last;
  logic              out_free;

  mfds_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .tick      (q_item.tick),
    .whole     (q_item.whole),
    .len       (eff_len),
    .done      (rem_done),
    .slot      (rem_slot),
    .whole_mod (rem_whole)
  );

  // right = (slot - n) mod L; both operands already below L
  assign right_c = (rem_slot >= rem_whole) ? (rem_slot - rem_whole)
                 : 7'(8'(rem_slot) + 8'(eff_len) - 8'(rem_whole));

  assign base_addr  = ADDR_W'(cur.chan) * ADDR_W'(DEPTH);
  assign prime_last = 32'(cnt) == DEPTH - 1;
  assign out_free   = !out_vld || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.kind == K_READ_BLANK) ? ST_EMIT : ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        unique case (cur.kind)
          K_PRIME:       state_next = ST_PRIME;
          K_READ_NOW:    state_next = ST_RD_NOW;
          K_READ_INTERP: state_next = ST_RD_LEFT;
          default:       state_next = ST_IDLE;
        endcase
      end
      ST_PRIME: begin
        if (prime_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_NOW:  state_next = ST_EMIT;
      ST_RD_LEFT: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_MUL;
      ST_MUL:     state_next = ST_SUM;
      ST_SUM:     state_next = ST_OFS;
      ST_OFS:     state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    rem_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = base_addr + ADDR_W'(slot_q);
    mem_wdata = cur.data;
    unique case (state)
      ST_IDLE: begin
        q_pop     = q_valid;
        rem_start = q_valid && (q_item.kind != K_READ_BLANK);
      end
      ST_ISSUE: begin
        unique case (cur.kind)
          K_WRITE:       mem_we = 1'b1;
          K_READ_NOW:    mem_re = 1'b1;
          K_READ_INTERP: begin
            mem_re   = 1'b1;
            mem_addr = base_addr + ADDR_W'(right_q);
          end
          default: ;
        endcase
      end
      ST_PRIME: begin
        mem_we   = 1'b1;
        mem_addr = base_addr + ADDR_W'(cnt);
      end
      ST_RD_LEFT: begin
        mem_re   = 1'b1;
        mem_addr = base_addr + ADDR_W'(left_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur <= q_item;
          res <= '0;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          slot_q  <= rem_slot;
          right_q <= right_c;
          left_q  <= (right_c == '0) ? (eff_len - 7'd1) : (right_c - 7'd1);
          cnt     <= '0;
        end
      end
      ST_PRIME: cnt <= cnt + 1'b1;
      ST_RD_NOW: res <= mem_rdata;
      ST_RD_LEFT: rgt <= mem_rdata;
      ST_RD_DATA: begin
        for (int i = 0; i < LANES; i++) begin
          diff[i] <= $signed({mem_rdata[SAMPLE_W*i+SAMPLE_W-1], mem_rdata[SAMPLE_W*i +: SAMPLE_W]})
                   - $signed({rgt[i][SAMPLE_W-1], rgt[i]});
        end
      end
      ST_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          prod[i] <= $signed({1'b0, cur.frac}) * diff[i];
        end
      end
      ST_SUM: begin
        // floor(f*d/256) added to right; the result stays within 32 bits
        for (int i = 0; i < LANES; i++) begin
          val[i] <= rgt[i] + prod[i][SAMPLE_W+7:8];
        end
      end
      ST_OFS: begin
        res[LANE_POS] <= (cur.chan == err_cfg.pos_ch)
                       ? sat_add(val[LANE_POS], err_cfg.pos_err) : val[LANE_POS];
        res[LANE_VEL] <= (cur.chan == err_cfg.vel_ch)
                       ? sat_add(val[LANE_VEL], err_cfg.vel_err) : val[LANE_VEL];
        res[LANE_ACC] <= val[LANE_ACC];
        res[LANE_LEN] <= val[LANE_LEN];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_chan <= cur.chan;
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign results.valid       = out_vld;
  assign results.channel_out = out_chan;
  assign results.pos_out     = out_data[LANE_POS];
  assign results.vel_out     = out_data[LANE_VEL];
  assign results.acc_out     = out_data[LANE_ACC];
  assign results.len_out     = out_data[LANE_LEN];

endmodule

@@ rtl/core/multichannel_fractional_delay_store.sv @@
// Per-channel ring histories of position, speed, acceleration and length (Q16.16),
// kept in one memory word per slot. Samples enter a two-entry command queue and a
// sequencer carries them out one at a time. The slot (tick mod history length) comes
// from a remainder unit that takes 8 dividend bits a cycle. An interpolated read
// makes two reads of the single memory port, then passes subtract, multiply, add
// and offset stages; a prime writes all DEPTH slots of the channel, one slot per
// cycle. The input side keeps accepting while the queue has room, and a finished
// result waits in the output register without blocking the next item. History
// storage is not cleared by reset: read only slots that were written or primed.
module multichannel_fractional_delay_store #(
  parameter int CHANNELS = 256,
  parameter int DEPTH    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mfds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfds_pkg::CFG_W-1:0]       cfg_wdata,
  mfds_in_if.sink                          samples,
  mfds_out_if.source                       results
);
  import mfds_pkg::*;

  localparam int ADDR_W = $clog2(CHANNELS * DEPTH);
  localparam int WORD_W = LANES * SAMPLE_W;

  logic [LEN_W-1:0] hist_len;
  logic [LEN_W-1:0] eff_len;
  err_cfg_t         err_cfg;

  logic  q_push;
  logic  q_ready;
  logic  q_pop;
  logic  q_valid;
  item_t push_item;
  item_t head_item;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= RESET_LEN;
      err_cfg  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIST_LEN: hist_len        <= cfg_wdata[LEN_W-1:0];
        CFG_POS_CH:   err_cfg.pos_ch  <= cfg_wdata[CHAN_W-1:0];
        CFG_POS_ERR:  err_cfg.pos_err <= cfg_wdata[SAMPLE_W-1:0];
        CFG_VEL_CH:   err_cfg.vel_ch  <= cfg_wdata[CHAN_W-1:0];
        CFG_VEL_ERR:  err_cfg.vel_err <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (hist_len < MIN_LEN) ? MIN_LEN
                 : ((32'(hist_len) > DEPTH) ? LEN_W'(DEPTH) : hist_len);

  mfds_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .samples (samples),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (push_item)
  );

  mfds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (head_item)
  );

  mfds_back #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .eff_len   (eff_len),
    .err_cfg   (err_cfg),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .results   (results)
  );

  mfds_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS * DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assert property (@(posedge clk) disable iff (rst) q_push |=> q_valid)
    else $error("queued transaction missing from command queue");

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty command queue");

  assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("history memory written and read in the same cycle");

endmodule
